// ----- rtl/assert_macros.svh -----
// Assertion macros used by the block's top-level RTL.
// Expects a clock named clock and a reset named reset in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked outside reset.
`define BWPH_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every edge, reset included.
`define BWPH_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- rtl/bwph_pkg.sv -----
// Types, codes and constants of the binary window pattern histogram.
// No dependencies.
package bwph_pkg;

   localparam logic [1:0] MODE_LOAD  = 2'd0;
   localparam logic [1:0] MODE_COUNT = 2'd1;
   localparam logic [1:0] MODE_EMIT  = 2'd2;
   localparam logic [1:0] MODE_NOP   = 2'd3;

   localparam logic [1:0] CSR_WIDTH     = 2'd0;
   localparam logic [1:0] CSR_HEIGHT    = 2'd1;
   localparam logic [1:0] CSR_MIN_COUNT = 2'd2;
   localparam logic [1:0] CSR_RECT_SIZE = 2'd3;

   localparam int CSR_DATA_BITS = 18;
   localparam int PAT_BITS      = 9;
   localparam int HIST_BINS     = 512;
   localparam int TAPS          = 9;
   localparam int CENTRE_BIT    = 4;

   localparam logic [31:0] WHITE_PIXEL = 32'hffff_ffff;

   localparam logic [9:0]  RST_WIDTH     = 10'd512;
   localparam logic [9:0]  RST_HEIGHT    = 10'd512;
   localparam logic [17:0] RST_MIN_COUNT = 18'd1;
   localparam logic [7:0]  RST_RECT_SIZE = 8'd8;

   typedef struct packed {
      logic       accept;
      logic       load;
      logic       fix;
      logic       rd_en;
      logic [3:0] tap;
      logic       cap_en;
      logic [3:0] cap_tap;
      logic       hist_rd;
      logic       count_upd;
      logic       emit_upd;
      logic       clr_en;
      logic [8:0] clr_addr;
   } cmd_type;

   typedef struct packed {
      logic new_frame;
      logic out_busy;
   } status_type;

   // window tap k sits at column offset k/3 and row offset k%3 (both minus one)
   function automatic logic [1:0] tap_dx(input logic [3:0] tap);
      logic [1:0] r;
      unique case (tap)
         4'd0, 4'd1, 4'd2: r = 2'd0;
         4'd3, 4'd4, 4'd5: r = 2'd1;
         default:          r = 2'd2;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] tap_dy(input logic [3:0] tap);
      logic [1:0] r;
      unique case (tap)
         4'd0, 4'd3, 4'd6: r = 2'd0;
         4'd1, 4'd4, 4'd7: r = 2'd1;
         default:          r = 2'd2;
      endcase
      return r;
   endfunction

endpackage

// ----- rtl/bwph_req_if.sv -----
// Request channel: mode and pixel with valid/ready.
// Depends on nothing.
interface bwph_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [31:0] pixel;

   modport source (output valid, output mode, output pixel, input ready);
   modport sink   (input valid, input mode, input pixel, output ready);
endinterface

// ----- rtl/bwph_rsp_if.sv -----
// Response channel: window position, pattern, rectangle and flags with valid/ready.
// Depends on nothing.
interface bwph_rsp_if;
   logic              valid;
   logic              ready;
   logic [8:0]        pos_x;
   logic [8:0]        pos_y;
   logic [8:0]        pattern;
   logic signed [9:0] rect_left;
   logic signed [9:0] rect_top;
   logic              is_candidate;
   logic              last;

   modport source (output valid, output pos_x, output pos_y, output pattern,
                   output rect_left, output rect_top, output is_candidate,
                   output last, input ready);
   modport sink   (input valid, input pos_x, input pos_y, input pattern,
                   input rect_left, input rect_top, input is_candidate,
                   input last, output ready);
endinterface

// ----- rtl/bwph_ctrl.sv -----
// Sequencer of the pattern histogram: clear sweep, load, window reads, bin update.
// Depends on bwph_pkg.
module bwph_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [1:0]           req_mode,
   output logic                 req_ready,
   input  bwph_pkg::status_type status,
   output bwph_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_LOAD, ST_FIX, ST_READ, ST_HREAD, ST_UPDATE
   } state_type;

   state_type  state_ff, state_in;
   logic [3:0] tap_ff, tap_in;
   logic [8:0] clr_ff, clr_in;
   logic       emit_ff, emit_in;
   logic       accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      tap_in   = tap_ff;
      clr_in   = clr_ff;
      emit_in  = emit_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 9'd1;
            if (clr_ff == 9'(bwph_pkg::HIST_BINS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               emit_in = (req_mode == bwph_pkg::MODE_EMIT);
               priority if (req_mode == bwph_pkg::MODE_LOAD) state_in = ST_LOAD;
               else if (req_mode == bwph_pkg::MODE_COUNT ||
                        req_mode == bwph_pkg::MODE_EMIT) state_in = ST_FIX;
               else state_in = ST_IDLE;
            end
         end
         ST_LOAD: begin
            clr_in   = 9'd0;
            state_in = status.new_frame ? ST_CLEAR : ST_IDLE;
         end
         ST_FIX: begin
            tap_in   = 4'd0;
            state_in = ST_READ;
         end
         ST_READ: begin
            tap_in = tap_ff + 4'd1;
            if (tap_ff == 4'(bwph_pkg::TAPS)) state_in = ST_HREAD;
         end
         ST_HREAD: state_in = ST_UPDATE;
         ST_UPDATE: begin
            if (!(emit_ff && status.out_busy)) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         tap_ff   <= 4'd0;
         clr_ff   <= 9'd0;
         emit_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         tap_ff   <= tap_in;
         clr_ff   <= clr_in;
         emit_ff  <= emit_in;
      end
   end

   always_comb begin
      cmd           = '0;
      cmd.accept    = accept;
      cmd.load      = (state_ff == ST_LOAD);
      cmd.fix       = (state_ff == ST_FIX);
      cmd.tap       = tap_ff;
      cmd.rd_en     = (state_ff == ST_READ) && (tap_ff < 4'(bwph_pkg::TAPS));
      cmd.cap_en    = (state_ff == ST_READ) && (tap_ff != 4'd0);
      cmd.cap_tap   = tap_ff - 4'd1;
      cmd.hist_rd   = (state_ff == ST_HREAD);
      cmd.count_upd = (state_ff == ST_UPDATE) && !emit_ff;
      cmd.emit_upd  = (state_ff == ST_UPDATE) && emit_ff && !status.out_busy;
      cmd.clr_en    = (state_ff == ST_CLEAR);
      cmd.clr_addr  = clr_ff;
   end

endmodule

// ----- rtl/bwph_datapath.sv -----
// Datapath: config registers, bitmap and histogram memories, positions, result register.
// Depends on bwph_pkg.
module bwph_datapath #(
   parameter int MAX_WIDTH  = 512,
   parameter int MAX_HEIGHT = 512,
   parameter int COUNT_BITS = 18
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [1:0]           csr_index,
   input  logic [bwph_pkg::CSR_DATA_BITS-1:0] csr_wr_data,
   input  logic [31:0]          req_pixel,
   input  bwph_pkg::cmd_type    cmd,
   output bwph_pkg::status_type status,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic [8:0]           rsp_pos_x,
   output logic [8:0]           rsp_pos_y,
   output logic [8:0]           rsp_pattern,
   output logic signed [9:0]    rsp_rect_left,
   output logic signed [9:0]    rsp_rect_top,
   output logic                 rsp_is_candidate,
   output logic                 rsp_last
);

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int RW    = $clog2(MAX_HEIGHT);
   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(DEPTH);

   logic [9:0]  fw_ff, fh_ff;
   logic [17:0] minc_ff;
   logic [7:0]  rsz_ff;
   logic [9:0]  eff_w, eff_h;

   logic [CW-1:0] load_col_ff, scan_col_ff;
   logic [RW-1:0] load_row_ff, scan_row_ff;
   logic          pix_set_ff;
   logic [bwph_pkg::PAT_BITS-1:0] pattern_ff;
   logic          rd_bit_ff;
   logic [COUNT_BITS-1:0] hist_q_ff;
   logic          rsp_valid_ff;

   logic          bitmap_mem [DEPTH];
   logic [COUNT_BITS-1:0] hist_mem [bwph_pkg::HIST_BINS];

   logic [31:0]   lc, lr, lc_nx, lr_nx;
   logic [31:0]   fc, fr, ac, ar, tx, ty, w2, h2;
   logic [AW-1:0] load_addr, tap_addr;
   logic          new_frame, hist_we;

   always_comb begin
      priority if (fw_ff < 10'd3) eff_w = 10'd3;
      else if (32'(fw_ff) > 32'(MAX_WIDTH)) eff_w = 10'(MAX_WIDTH);
      else eff_w = fw_ff;
      priority if (fh_ff < 10'd3) eff_h = 10'd3;
      else if (32'(fh_ff) > 32'(MAX_HEIGHT)) eff_h = 10'(MAX_HEIGHT);
      else eff_h = fh_ff;
   end

   assign w2 = 32'(eff_w) - 32'd2;
   assign h2 = 32'(eff_h) - 32'd2;

   // load position: wrap out-of-range, write, advance
   always_comb begin
      lc = 32'(load_col_ff);
      lr = 32'(load_row_ff);
      if (lc >= 32'(eff_w)) begin
         lc = 32'd0;
         lr = lr + 32'd1;
      end
      if (lr >= 32'(eff_h)) lr = 32'd0;
      new_frame = (lc == 32'd0) && (lr == 32'd0);
      load_addr = AW'(lr * 32'(MAX_WIDTH) + lc);
      lc_nx = lc + 32'd1;
      lr_nx = lr;
      if (lc_nx >= 32'(eff_w)) begin
         lc_nx = 32'd0;
         lr_nx = lr + 32'd1;
         if (lr_nx >= 32'(eff_h)) lr_nx = 32'd0;
      end
   end

   // scan position: fix before use, advance after
   always_comb begin
      fc = 32'(scan_col_ff);
      fr = 32'(scan_row_ff);
      if (fc < 32'd1) fc = 32'd1;
      if (fr < 32'd1) fr = 32'd1;
      if (fc > w2) begin
         fc = 32'd1;
         fr = fr + 32'd1;
      end
      if (fr > h2) fr = 32'd1;
      ac = 32'(scan_col_ff) + 32'd1;
      ar = 32'(scan_row_ff);
      if (ac > w2) begin
         ac = 32'd1;
         ar = ar + 32'd1;
         if (ar > h2) ar = 32'd1;
      end
      tx = 32'(scan_col_ff) + 32'(bwph_pkg::tap_dx(cmd.tap)) - 32'd1;
      ty = 32'(scan_row_ff) + 32'(bwph_pkg::tap_dy(cmd.tap)) - 32'd1;
      tap_addr = AW'(ty * 32'(MAX_WIDTH) + tx);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff       <= bwph_pkg::RST_WIDTH;
         fh_ff       <= bwph_pkg::RST_HEIGHT;
         minc_ff     <= bwph_pkg::RST_MIN_COUNT;
         rsz_ff      <= bwph_pkg::RST_RECT_SIZE;
         load_col_ff <= '0;
         load_row_ff <= '0;
         scan_col_ff <= CW'(1);
         scan_row_ff <= RW'(1);
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               bwph_pkg::CSR_WIDTH:     fw_ff   <= csr_wr_data[9:0];
               bwph_pkg::CSR_HEIGHT:    fh_ff   <= csr_wr_data[9:0];
               bwph_pkg::CSR_MIN_COUNT: minc_ff <= csr_wr_data;
               bwph_pkg::CSR_RECT_SIZE: rsz_ff  <= csr_wr_data[7:0];
            endcase
         end
         if (cmd.load) begin
            load_col_ff <= CW'(lc_nx);
            load_row_ff <= RW'(lr_nx);
         end
         priority if (cmd.load && new_frame) begin
            scan_col_ff <= CW'(1);
            scan_row_ff <= RW'(1);
         end else if (cmd.fix) begin
            scan_col_ff <= CW'(fc);
            scan_row_ff <= RW'(fr);
         end else if (cmd.count_upd || cmd.emit_upd) begin
            scan_col_ff <= CW'(ac);
            scan_row_ff <= RW'(ar);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) pix_set_ff <= (req_pixel != bwph_pkg::WHITE_PIXEL);
      if (cmd.cap_en) pattern_ff[cmd.cap_tap] <= rd_bit_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) bitmap_mem[load_addr] <= pix_set_ff;
      if (cmd.rd_en) rd_bit_ff <= bitmap_mem[tap_addr];
   end

   assign hist_we = cmd.count_upd && (pattern_ff != '0) && (hist_q_ff != '1);

   always_ff @(posedge clock) begin
      if (cmd.clr_en) hist_mem[cmd.clr_addr] <= '0;
      else if (hist_we) hist_mem[pattern_ff] <= hist_q_ff + COUNT_BITS'(1);
      if (cmd.hist_rd) hist_q_ff <= hist_mem[pattern_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.emit_upd) rsp_valid_ff <= 1'b1;
      else if (rsp_ready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_upd) begin
         rsp_pos_x        <= 9'(scan_col_ff);
         rsp_pos_y        <= 9'(scan_row_ff);
         rsp_pattern      <= pattern_ff;
         rsp_rect_left    <= 10'(32'(scan_col_ff) - 32'(rsz_ff[7:1]));
         rsp_rect_top     <= 10'(32'(scan_row_ff) - 32'(rsz_ff[7:1]));
         rsp_is_candidate <= pattern_ff[bwph_pkg::CENTRE_BIT] &&
                             (32'(hist_q_ff) >= 32'(minc_ff));
         rsp_last         <= (32'(scan_col_ff) == w2) && (32'(scan_row_ff) == h2);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign status.new_frame = new_frame;
   assign status.out_busy  = rsp_valid_ff && !rsp_ready;

endmodule

// ----- rtl/binary_window_pattern_histogram.sv -----
// Top level of the binary 3x3 window pattern histogram.
// Depends on bwph_pkg, bwph_req_if, bwph_rsp_if, bwph_ctrl, bwph_datapath, assert_macros.svh.
//
// Load transactions store one bit per pixel (set when not pure white) in raster order;
// count transactions bin the 3x3 pattern of each interior position; emit transactions
// return pattern, rectangle and candidate flag per interior position. For counts and
// emits the nine window bits are read one per cycle from the single-port bitmap memory,
// then the bin is read and, for a count, written back. After reset, and after a load
// that starts a new frame, a clearing pass zeroes the histogram while req_chan.ready
// stays low. Mode 3 is taken and ignored.
`include "assert_macros.svh"
module binary_window_pattern_histogram #(
   parameter int MAX_WIDTH  = 512,
   parameter int MAX_HEIGHT = 512,
   parameter int COUNT_BITS = 18
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_index,
   input  logic [bwph_pkg::CSR_DATA_BITS-1:0] csr_wr_data,
   bwph_req_if.sink   req_chan,
   bwph_rsp_if.source rsp_chan
);

   bwph_pkg::cmd_type    cmd;
   bwph_pkg::status_type status;
   logic                 req_ready;

   assign req_chan.ready = req_ready;

   bwph_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_mode  (req_chan.mode),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   bwph_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data),
      .req_pixel        (req_chan.pixel),
      .cmd              (cmd),
      .status           (status),
      .rsp_ready        (rsp_chan.ready),
      .rsp_valid        (rsp_chan.valid),
      .rsp_pos_x        (rsp_chan.pos_x),
      .rsp_pos_y        (rsp_chan.pos_y),
      .rsp_pattern      (rsp_chan.pattern),
      .rsp_rect_left    (rsp_chan.rect_left),
      .rsp_rect_top     (rsp_chan.rect_top),
      .rsp_is_candidate (rsp_chan.is_candidate),
      .rsp_last         (rsp_chan.last)
   );

   `BWPH_ASSERT(a_busy_after_accept, (req_chan.valid && req_chan.ready && req_chan.mode != bwph_pkg::MODE_NOP) |=> !req_chan.ready, "ready high right after a working transaction")
   `BWPH_ASSERT(a_no_rsp_without_emit, (req_chan.valid && req_chan.ready && req_chan.mode != bwph_pkg::MODE_EMIT) |=> !$rose(rsp_chan.valid), "response without emit")
   `BWPH_ASSERT_ALWAYS(a_clear_after_reset, reset |=> !req_chan.ready, "ready during clearing pass")

endmodule

// ----- dv/bwph_checker.sv -----
// Scoreboard for binary_window_pattern_histogram: watches the csr port and both channels,
// predicts every emit result and compares it field by field. Depends on bwph_pkg and the
// bwph_req_if / bwph_rsp_if interfaces.
module bwph_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [1:0]                         csr_index,
   input  logic [bwph_pkg::CSR_DATA_BITS-1:0] csr_wr_data,
   bwph_req_if                                req_mon,
   bwph_rsp_if                                rsp_mon,
   output int                                 fail_count,
   output int                                 pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAME_MAX = 512;
   localparam int BIN_MAX   = (1 << 18) - 1;

   typedef struct {
      logic [8:0]        pos_x;
      logic [8:0]        pos_y;
      logic [8:0]        pattern;
      logic signed [9:0] rect_left;
      logic signed [9:0] rect_top;
      logic              is_candidate;
      logic              last;
   } window_result_type;

   window_result_type expected_windows[$];

   bit          pixel_map[FRAME_MAX*FRAME_MAX];
   int unsigned bin_count[bwph_pkg::HIST_BINS];
   int unsigned load_x, load_y, scan_x, scan_y;
   int unsigned frame_w, frame_h, min_hits, rect_side;

   function automatic int unsigned clamp_size(input int unsigned v);
      return (v < 3) ? 3 : (v > FRAME_MAX) ? FRAME_MAX : v;
   endfunction

   function automatic logic [8:0] window_bits(input int unsigned x, input int unsigned y);
      logic [8:0] pat;
      pat = '0;
      for (int dx = 0; dx < 3; dx++)
         for (int dy = 0; dy < 3; dy++)
            pat[dx*3+dy] = pixel_map[(y + dy - 1) * FRAME_MAX + (x + dx - 1)];
      return pat;
   endfunction

   task automatic step_histogram(input logic [1:0] mode, input logic [31:0] pixel);
      int unsigned w, h;
      logic [8:0] pat;
      window_result_type res;
      w = clamp_size(frame_w);
      h = clamp_size(frame_h);
      if (mode == bwph_pkg::MODE_LOAD) begin
         if (load_x >= w) begin
            load_x = 0;
            load_y++;
         end
         if (load_y >= h) load_y = 0;
         if (load_x == 0 && load_y == 0) begin
            foreach (bin_count[i]) bin_count[i] = 0;
            scan_x = 1;
            scan_y = 1;
         end
         pixel_map[load_y * FRAME_MAX + load_x] = (pixel != bwph_pkg::WHITE_PIXEL);
         load_x++;
         if (load_x >= w) begin
            load_x = 0;
            load_y++;
            if (load_y >= h) load_y = 0;
         end
      end else if (mode == bwph_pkg::MODE_COUNT || mode == bwph_pkg::MODE_EMIT) begin
         if (scan_x < 1) scan_x = 1;
         if (scan_y < 1) scan_y = 1;
         if (scan_x > w - 2) begin
            scan_x = 1;
            scan_y++;
         end
         if (scan_y > h - 2) scan_y = 1;
         pat = window_bits(scan_x, scan_y);
         if (mode == bwph_pkg::MODE_COUNT) begin
            if (pat != 0 && bin_count[pat] < BIN_MAX) bin_count[pat]++;
         end else begin
            res.pos_x        = scan_x[8:0];
            res.pos_y        = scan_y[8:0];
            res.pattern      = pat;
            res.rect_left    = 10'(int'(scan_x) - int'(rect_side / 2));
            res.rect_top     = 10'(int'(scan_y) - int'(rect_side / 2));
            res.is_candidate = pat[bwph_pkg::CENTRE_BIT] && (bin_count[pat] >= min_hits);
            res.last         = (scan_x == w - 2) && (scan_y == h - 2);
            expected_windows.insert(expected_windows.size(), res);
         end
         scan_x++;
         if (scan_x > w - 2) begin
            scan_x = 1;
            scan_y++;
            if (scan_y > h - 2) scan_y = 1;
         end
      end
   endtask

   task automatic report(input string field, input int got, input int want);
      $display("[%0t] window mismatch on %s: got %0d, expected %0d", $realtime, field, got,
               want);
      fail_count++;
   endtask

   task automatic check_window();
      window_result_type w;
      if (expected_windows.size() == 0) begin
         report("unexpected transaction", 1, 0);
         return;
      end
      w = expected_windows.pop_front();
      if (rsp_mon.pos_x !== w.pos_x) report("pos_x", rsp_mon.pos_x, w.pos_x);
      if (rsp_mon.pos_y !== w.pos_y) report("pos_y", rsp_mon.pos_y, w.pos_y);
      if (rsp_mon.pattern !== w.pattern) report("pattern", rsp_mon.pattern, w.pattern);
      if (rsp_mon.rect_left !== w.rect_left)
         report("rect_left", rsp_mon.rect_left, w.rect_left);
      if (rsp_mon.rect_top !== w.rect_top) report("rect_top", rsp_mon.rect_top, w.rect_top);
      if (rsp_mon.is_candidate !== w.is_candidate)
         report("is_candidate", rsp_mon.is_candidate, w.is_candidate);
      if (rsp_mon.last !== w.last) report("last", rsp_mon.last, w.last);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         foreach (bin_count[i]) bin_count[i] = 0;
         fail_count = 0;
         load_x    = 0;
         load_y    = 0;
         scan_x    = 1;
         scan_y    = 1;
         frame_w   = bwph_pkg::RST_WIDTH;
         frame_h   = bwph_pkg::RST_HEIGHT;
         min_hits  = bwph_pkg::RST_MIN_COUNT;
         rect_side = bwph_pkg::RST_RECT_SIZE;
         expected_windows.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               bwph_pkg::CSR_WIDTH:     frame_w   = csr_wr_data[9:0];
               bwph_pkg::CSR_HEIGHT:    frame_h   = csr_wr_data[9:0];
               bwph_pkg::CSR_MIN_COUNT: min_hits  = csr_wr_data[17:0];
               bwph_pkg::CSR_RECT_SIZE: rect_side = csr_wr_data[7:0];
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) check_window();
         if (req_mon.valid && req_mon.ready) step_histogram(req_mon.mode, req_mon.pixel);
      end
      pending = expected_windows.size();
   end

endmodule

// ----- dv/binary_window_pattern_histogram_tb.sv -----
// Testbench top for binary_window_pattern_histogram: clock, reset, csr phases, random
// stimulus with idling and back-pressure, and the verdict. Depends on bwph_pkg, the
// channel interfaces, bwph_checker and the RTL.
module binary_window_pattern_histogram_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 1500000;
   localparam int TARGET_ITEMS = 1950;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [1:0] csr_index = bwph_pkg::CSR_WIDTH;
   logic [bwph_pkg::CSR_DATA_BITS-1:0] csr_wr_data = '0;
   int fail_count, pending, items_sent, cycles;
   bit steady_send, steady_recv, hold_request;

   bwph_req_if req_chan ();
   bwph_rsp_if rsp_chan ();

   binary_window_pattern_histogram u_top (
      .clock(clock), .reset(reset), .csr_wr_en(csr_wr_en), .csr_index(csr_index),
      .csr_wr_data(csr_wr_data), .req_chan(req_chan), .rsp_chan(rsp_chan)
   );

   bwph_checker u_checker (
      .clock(clock), .reset(reset), .csr_wr_en(csr_wr_en), .csr_index(csr_index),
      .csr_wr_data(csr_wr_data), .req_mon(req_chan), .rsp_mon(rsp_chan),
      .fail_count(fail_count), .pending(pending)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("binary_window_pattern_histogram regression: fail");
         $finish;
      end
   end

   // response side: random stalls, plus a long hold-off on request
   always @(negedge clock) begin : rsp_drive
      int hold_left;
      if (reset) begin
         rsp_chan.ready = 1'b0;
         hold_left = 0;
      end else begin
         if (hold_request) begin
            hold_left = 400;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready = 1'b0;
         end else begin
            rsp_chan.ready = steady_recv || ($urandom_range(0, 99) >= 20);
         end
      end
   end

   task automatic send(input logic [1:0] mode, input logic [31:0] pixel);
      @(negedge clock);
      while (!steady_send && $urandom_range(0, 99) < 20) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid = 1'b1;
      req_chan.mode  = mode;
      req_chan.pixel = pixel;
      do @(posedge clock); while (!req_chan.ready);
      items_sent++;
   endtask

   task automatic go_quiet();
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input int unsigned value);
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_index   = idx;
      csr_wr_data = value[bwph_pkg::CSR_DATA_BITS-1:0];
      @(negedge clock);
      csr_wr_en   = 1'b0;
   endtask

   function automatic logic [31:0] random_pixel();
      return ($urandom_range(0, 1) == 1) ? bwph_pkg::WHITE_PIXEL : $urandom;
   endfunction

   // program a frame geometry and load one full frame so every window is defined
   task automatic start_frame(input int unsigned w, input int unsigned h,
                              input int unsigned min_hits, input int unsigned side);
      int unsigned ew, eh;
      go_quiet();
      csr_write(bwph_pkg::CSR_WIDTH, w);
      csr_write(bwph_pkg::CSR_HEIGHT, h);
      csr_write(bwph_pkg::CSR_MIN_COUNT, min_hits);
      csr_write(bwph_pkg::CSR_RECT_SIZE, side);
      ew = (w < 3) ? 3 : (w > 512) ? 512 : w;
      eh = (h < 3) ? 3 : (h > 512) ? 512 : h;
      repeat (ew * eh) send(bwph_pkg::MODE_LOAD, random_pixel());
   endtask

   task automatic random_ops(input int n);
      int pick;
      repeat (n) begin
         pick = $urandom_range(0, 99);
         if (pick < 45)      send(bwph_pkg::MODE_COUNT, $urandom);
         else if (pick < 85) send(bwph_pkg::MODE_EMIT, $urandom);
         else if (pick < 95) send(bwph_pkg::MODE_LOAD, random_pixel());
         else                send(bwph_pkg::MODE_NOP, $urandom);
      end
   endtask

   initial begin
      req_chan.valid = 1'b0;
      req_chan.mode  = bwph_pkg::MODE_NOP;
      req_chan.pixel = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // single interior position, clamped width, extreme csr values
      go_quiet();
      csr_write(bwph_pkg::CSR_WIDTH, 0);
      csr_write(bwph_pkg::CSR_HEIGHT, 3);
      csr_write(bwph_pkg::CSR_MIN_COUNT, 0);
      csr_write(bwph_pkg::CSR_RECT_SIZE, 255);
      send(bwph_pkg::MODE_LOAD, 32'h0000_0000);
      send(bwph_pkg::MODE_LOAD, bwph_pkg::WHITE_PIXEL);
      send(bwph_pkg::MODE_LOAD, 32'hffff_fffe);
      send(bwph_pkg::MODE_LOAD, 32'h7fff_ffff);
      send(bwph_pkg::MODE_LOAD, 32'hdead_beef);
      send(bwph_pkg::MODE_LOAD, bwph_pkg::WHITE_PIXEL);
      send(bwph_pkg::MODE_LOAD, 32'h0000_0001);
      send(bwph_pkg::MODE_LOAD, 32'h8000_0000);
      send(bwph_pkg::MODE_LOAD, bwph_pkg::WHITE_PIXEL);
      send(bwph_pkg::MODE_EMIT, '0);
      send(bwph_pkg::MODE_COUNT, '0);
      send(bwph_pkg::MODE_COUNT, '0);
      send(bwph_pkg::MODE_EMIT, '1);
      send(bwph_pkg::MODE_NOP, '1);
      send(bwph_pkg::MODE_EMIT, '0);

      // widest frame, no idling on either side
      steady_send = 1'b1;
      steady_recv = 1'b1;
      start_frame(1023, 3, 262143, 0);
      random_ops(60);
      steady_send = 1'b0;
      steady_recv = 1'b0;

      // back-pressure: receiver holds off while emits keep coming
      start_frame(6, 5, 1, 8);
      steady_send  = 1'b1;
      hold_request = 1'b1;
      repeat (40) send(bwph_pkg::MODE_EMIT, $urandom);
      steady_send  = 1'b0;
      go_quiet();

      while (items_sent < TARGET_ITEMS) begin
         steady_send = ($urandom_range(0, 5) == 0);
         steady_recv = ($urandom_range(0, 5) == 0);
         start_frame($urandom_range(3, 12), $urandom_range(3, 12),
                     ($urandom_range(0, 9) == 0) ? 262143 : $urandom_range(0, 4),
                     $urandom_range(0, 255));
         random_ops(100);
      end
      steady_send = 1'b0;
      steady_recv = 1'b0;

      @(negedge clock);
      req_chan.valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (50) @(negedge clock);
      if (fail_count == 0)
         $display("binary_window_pattern_histogram regression: pass");
      else
         $display("binary_window_pattern_histogram regression: fail");
      $finish;
   end

endmodule
